// ----- hdl/pvbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbe_pkg: shared types and constants for the delta vbyte postings encoder
// Command format passed from the front end to the byte emitter, widths and
// queue sizing.
// ----------------------------------------------------------------------------
package pvbe_pkg;

  localparam int DOC_W        = 35;
  localparam int FREQ_W       = 8;
  localparam int BYTE_W       = 8;
  localparam int GROUP_BITS   = 7;
  localparam int GAP_GROUPS   = 5;
  localparam int GRP_W        = $clog2(GAP_GROUPS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(255);

  // Request kinds
  localparam logic REQ_POSTING = 1'b0;
  localparam logic REQ_FLUSH   = 1'b1;

  // Result stream kinds
  localparam logic KIND_GAP  = 1'b0;
  localparam logic KIND_FREQ = 1'b1;

  // One unit of work for the back end: optional frequency byte, then optional gap
  typedef struct packed {
    logic              emit_freq;
    logic [FREQ_W-1:0] freq;
    logic              emit_gap;
    logic [DOC_W-1:0]  gap;
  } cmd_t;

endpackage

// ----- hdl/pvbe_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbe_front: request classifier and term state
// Tracks previous document and pending frequency, and turns each request into
// a command for the byte emitter when the request produces output.
// ----------------------------------------------------------------------------
module pvbe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [pvbe_pkg::DOC_W-1:0] in_doc_number,
  output logic                  push,
  output pvbe_pkg::cmd_t        push_cmd
);
  import pvbe_pkg::*;

  logic [DOC_W-1:0]  prev_doc_r,  prev_doc_nxt;
  logic [FREQ_W-1:0] freq_r,      freq_nxt;
  logic              have_doc_r,  have_doc_nxt;
  logic              accept;

  assign accept = in_valid && in_ready;

  // Classify request and compute next term state
  always_comb begin
    prev_doc_nxt       = prev_doc_r;
    freq_nxt           = freq_r;
    have_doc_nxt       = have_doc_r;
    push               = 1'b0;
    push_cmd.emit_freq = have_doc_r;
    push_cmd.freq      = freq_r;
    push_cmd.emit_gap  = 1'b0;
    push_cmd.gap       = in_doc_number - prev_doc_r;
    if (accept) begin
      if (in_req_type == REQ_FLUSH) begin
        push         = have_doc_r;
        prev_doc_nxt = '0;
        freq_nxt     = '0;
        have_doc_nxt = 1'b0;
      end else if (have_doc_r && (in_doc_number == prev_doc_r)) begin
        // repeated document: count it, saturating
        if (freq_r != FREQ_MAX) begin
          freq_nxt = freq_r + FREQ_W'(1);
        end
      end else begin
        push              = 1'b1;
        push_cmd.emit_gap = 1'b1;
        prev_doc_nxt      = in_doc_number;
        freq_nxt          = FREQ_W'(1);
        have_doc_nxt      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_doc_r <= '0;
      freq_r     <= '0;
      have_doc_r <= 1'b0;
    end else begin
      prev_doc_r <= prev_doc_nxt;
      freq_r     <= freq_nxt;
      have_doc_r <= have_doc_nxt;
    end
  end

endmodule

// ----- hdl/pvbe_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbe_queue: command queue between front end and byte emitter
// Small circular buffer with a fill count; head is shown combinationally.
// ----------------------------------------------------------------------------
module pvbe_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pvbe_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output pvbe_pkg::cmd_t head_cmd
);
  import pvbe_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rptr_r];

  // Pointer and fill count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hdl/pvbe_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbe_back: byte emitter
// Pops commands and emits the frequency byte and the big-endian 7-bit gap
// groups one per cycle, unless out_ready stalls, into an output register.
// ----------------------------------------------------------------------------
module pvbe_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_valid,
  input  pvbe_pkg::cmd_t             head_cmd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_stream_kind,
  output logic [pvbe_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import pvbe_pkg::*;

  // Current command
  logic              cur_valid_r, cur_valid_nxt;
  logic              cur_freq_r,  cur_freq_nxt;
  logic              cur_gap_r,   cur_gap_nxt;
  logic [FREQ_W-1:0] freq_r,      freq_nxt;
  logic [DOC_W-1:0]  gap_r,       gap_nxt;
  logic [GRP_W-1:0]  idx_r,       idx_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              kind_r,      kind_nxt;
  logic [BYTE_W-1:0] byte_r,      byte_nxt;
  logic              last_r,      last_nxt;

  logic              load;
  logic              emit;
  logic              done;
  logic [GRP_W-1:0]  top_idx;
  logic [DOC_W-1:0]  shifted;

  assign load = !out_valid_r || out_ready;
  assign emit = cur_valid_r && load;

  // Highest nonzero group of the incoming gap, capped by the group count
  always_comb begin
    top_idx = '0;
    for (int g = 1; g < GAP_GROUPS; g++) begin
      if ((head_cmd.gap >> (GROUP_BITS * g)) != '0) begin
        top_idx = GRP_W'(g);
      end
    end
  end

  assign shifted = gap_r >> (GROUP_BITS * idx_r);

  // Byte selection and command sequencing
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_freq_nxt  = cur_freq_r;
    cur_gap_nxt   = cur_gap_r;
    freq_nxt      = freq_r;
    gap_nxt       = gap_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    done          = 1'b0;

    if (load) begin
      out_valid_nxt = emit;
    end

    if (emit) begin
      if (cur_freq_r) begin
        kind_nxt     = KIND_FREQ;
        byte_nxt     = freq_r;
        last_nxt     = !cur_gap_r;
        done         = !cur_gap_r;
        cur_freq_nxt = 1'b0;
      end else begin
        kind_nxt = KIND_GAP;
        byte_nxt = {(idx_r == '0), shifted[GROUP_BITS-1:0]};
        last_nxt = (idx_r == '0);
        done     = (idx_r == '0);
        idx_nxt  = idx_r - GRP_W'(1);
      end
    end

    pop = head_valid && (!cur_valid_r || (emit && done));

    if (pop) begin
      cur_valid_nxt = 1'b1;
      cur_freq_nxt  = head_cmd.emit_freq;
      cur_gap_nxt   = head_cmd.emit_gap;
      freq_nxt      = head_cmd.freq;
      gap_nxt       = head_cmd.gap;
      idx_nxt       = top_idx;
    end else if (emit && done) begin
      cur_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cur_freq_r  <= 1'b0;
      cur_gap_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cur_freq_r  <= cur_freq_nxt;
      cur_gap_r   <= cur_gap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    freq_r <= freq_nxt;
    gap_r  <= gap_nxt;
    idx_r  <= idx_nxt;
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_stream_kind = kind_r;
  assign out_byte        = byte_r;
  assign out_last        = last_r;

endmodule

// ----- hdl/posting_delta_vbyte_encoder_core.sv -----
`timescale 1ns / 1ps
// A request's command passes through the command queue, the byte emitter's current
// command and the output register. Throughput: one result byte per cycle unless
//   out_ready stalls the output; a request yields 0 to 6 bytes.
// A 2-entry command queue lets the input side keep accepting while bytes drain.
// Reset (rst_n low, synchronous) clears term state, queue and output valid.
// ----------------------------------------------------------------------------
// posting_delta_vbyte_encoder_core: delta variable-byte postings encoder
// Front end classifies postings, queue decouples, back end emits bytes.
// ----------------------------------------------------------------------------
module posting_delta_vbyte_encoder_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_req_type,
  input  logic [pvbe_pkg::DOC_W-1:0]  in_doc_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_stream_kind,
  output logic [pvbe_pkg::BYTE_W-1:0] out_byte,
  output logic                        out_last
);
  import pvbe_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign in_ready = !full;

  pvbe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_doc_number (in_doc_number),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  pvbe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  pvbe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stream_kind (out_stream_kind),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

endmodule

// ----- sim/tb_posting_delta_vbyte_encoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_posting_delta_vbyte_encoder_core: self-checking bench for the postings encoder
// Drives postings and flushes over a valid/ready request channel with random
// gaps and output stalls. An in-bench encoder model predicts the frequency and gap
// bytes, or a directed row gives them by hand; accepted bytes are checked in order.
// A short table of hand-picked requests runs first, then random terms.
// ----------------------------------------------------------------------------
module tb_posting_delta_vbyte_encoder_core;
  import pvbe_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_WAIT       = 10;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int TAIL_CYCLES    = 16;
  localparam int RANDOM_ITEMS   = 128;
  localparam int FROM_PREDICTOR = -1;

  localparam logic [DOC_W-1:0] DOC_MAX = '1;

  // One output byte as seen on the result channel
  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_res_t;

  // One row of the directed table; n_typed of FROM_PREDICTOR means use the model
  typedef struct packed {
    logic             kind;
    logic [DOC_W-1:0] doc;
    int               n_typed;
    byte_res_t [4:0]  typed;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_req_type = REQ_POSTING;
  logic [DOC_W-1:0]  in_doc_number = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_stream_kind;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  posting_delta_vbyte_encoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_doc_number   (in_doc_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stream_kind (out_stream_kind),
    .out_byte        (out_byte),
    .out_last        (out_last)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Encoder model state
  logic [DOC_W-1:0]  model_prev_doc  = '0;
  logic [FREQ_W-1:0] model_freq      = '0;
  logic              model_have_doc  = 1'b0;
  byte_res_t         enc_buf [6];
  byte_res_t         expected_bytes [$];

  // Hand-typed expectation for the current directed row
  int                typed_n = FROM_PREDICTOR;
  byte_res_t [4:0]   typed_res;

  int  err_count     = 0;
  int  req_count     = 0;
  int  flush_count   = 0;
  int  byte_count    = 0;
  int  cycle_count   = 0;
  int  next_gap      = 0;
  bit  send_fast     = 1'b0;
  bit  recv_fast     = 1'b0;

  function automatic byte_res_t gap_b(logic [BYTE_W-1:0] v, logic l);
    return '{KIND_GAP, v, l};
  endfunction

  function automatic byte_res_t freq_b(logic [BYTE_W-1:0] v, logic l);
    return '{KIND_FREQ, v, l};
  endfunction

  function automatic dir_row_t mk_row(logic kind, logic [DOC_W-1:0] doc, int n,
                                      byte_res_t b0 = '0, byte_res_t b1 = '0,
                                      byte_res_t b2 = '0, byte_res_t b3 = '0,
                                      byte_res_t b4 = '0);
    dir_row_t r;
    r.kind     = kind;
    r.doc      = doc;
    r.n_typed  = n;
    r.typed[0] = b0;
    r.typed[1] = b1;
    r.typed[2] = b2;
    r.typed[3] = b3;
    r.typed[4] = b4;
    return r;
  endfunction

  function automatic logic [DOC_W-1:0] rand_doc();
    return DOC_W'({$urandom, $urandom});
  endfunction

  // Random gap with a random bit length, so every group count shows up
  function automatic logic [DOC_W-1:0] rand_gap();
    logic [63:0] mask;
    mask = (64'd1 << $urandom_range(0, DOC_W)) - 64'd1;
    return DOC_W'({$urandom, $urandom} & mask);
  endfunction

  function automatic int pick_wait(bit fast);
    return fast ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Encode one request into enc_buf; returns the number of bytes it yields
  function automatic int encode_req(logic kind, logic [DOC_W-1:0] doc);
    logic [DOC_W-1:0] gap;
    int groups;
    int n;
    n = 0;
    if (kind == REQ_FLUSH) begin
      if (model_have_doc) begin
        enc_buf[n] = freq_b(model_freq, 1'b0);
        n = n + 1;
      end
      model_prev_doc = '0;
      model_freq     = '0;
      model_have_doc = 1'b0;
    end else if (model_have_doc && doc == model_prev_doc) begin
      // same document again: count it, saturating
      if (model_freq != FREQ_MAX) model_freq = model_freq + FREQ_W'(1);
    end else begin
      gap = doc - model_prev_doc;
      if (model_have_doc) begin
        enc_buf[n] = freq_b(model_freq, 1'b0);
        n = n + 1;
      end
      groups = 1;
      while (groups < GAP_GROUPS && (gap >> (GROUP_BITS * groups)) != '0)
        groups = groups + 1;
      // big-endian 7-bit groups, stop bit on the final one
      for (int g = groups - 1; g >= 0; g--) begin
        enc_buf[n] = gap_b({(g == 0), 7'(gap >> (GROUP_BITS * g))}, 1'b0);
        n = n + 1;
      end
      model_prev_doc = doc;
      model_freq     = FREQ_W'(1);
      model_have_doc = 1'b1;
    end
    if (n > 0) enc_buf[n-1].last = 1'b1;
    return n;
  endfunction

  // Issue one request; at entry and exit we sit at a falling edge
  task automatic send_req(input logic kind, input logic [DOC_W-1:0] doc);
    int n;
    if (next_gap > 0) repeat (next_gap) @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_doc_number <= doc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n = encode_req(kind, doc);
    if (typed_n != FROM_PREDICTOR) begin
      for (int i = 0; i < typed_n; i++) expected_bytes.push_back(typed_res[i]);
    end else begin
      for (int i = 0; i < n; i++) expected_bytes.push_back(enc_buf[i]);
    end
    req_count = req_count + 1;
    if (kind == REQ_FLUSH) flush_count = flush_count + 1;
    @(negedge clk);
    if ($urandom_range(0, 24) == 0) send_fast = !send_fast;
    next_gap = pick_wait(send_fast);
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  // Hold the request side off until every expected byte has come out
  task automatic pause_sender();
    if (next_gap == 0) begin
      in_valid <= 1'b0;
      next_gap = 1;
    end
    while (expected_bytes.size() != 0) @(negedge clk);
  endtask

  // Result side: random stalls, check each accepted byte against the oldest expectation
  initial begin
    int stall;
    byte_res_t want;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 24) == 0) recv_fast = !recv_fast;
      stall = pick_wait(recv_fast);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      byte_count = byte_count + 1;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte kind=%0d byte=%02h last=%0d",
                 $time, out_stream_kind, out_byte, out_last);
        err_count = err_count + 1;
      end else begin
        want = expected_bytes.pop_front();
        if (out_stream_kind !== want.kind) begin
          $display("%0t: stream_kind expected %0d actual %0d",
                   $time, want.kind, out_stream_kind);
          err_count = err_count + 1;
        end
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          err_count = err_count + 1;
        end
        if (out_last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_last);
          err_count = err_count + 1;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("posting_delta_vbyte_encoder_core: mismatch");
      $finish;
    end
  end

  // Stimulus
  initial begin
    dir_row_t dir_tab [$];
    logic [DOC_W-1:0] doc;
    int items;
    int n_docs;
    int reps;
    bit mid_drained;

    // first posting from reset, repeat, flushes, extremes of the gap
    dir_tab.push_back(mk_row(REQ_POSTING, '0, 1, gap_b(8'h80, 1'b1)));
    dir_tab.push_back(mk_row(REQ_POSTING, '0, 0));
    dir_tab.push_back(mk_row(REQ_FLUSH, DOC_MAX, 1, freq_b(8'h02, 1'b1)));
    dir_tab.push_back(mk_row(REQ_FLUSH, '0, 0));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_MAX, 5, gap_b(8'h7F, 1'b0),
                             gap_b(8'h7F, 1'b0), gap_b(8'h7F, 1'b0),
                             gap_b(8'h7F, 1'b0), gap_b(8'hFF, 1'b1)));
    dir_tab.push_back(mk_row(REQ_FLUSH, '0, 1, freq_b(8'h01, 1'b1)));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(127), 1, gap_b(8'hFF, 1'b1)));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(128), 2, freq_b(8'h01, 1'b0),
                             gap_b(8'h81, 1'b1)));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(256), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(256 + 16383), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(256 + 16384), FROM_PREDICTOR));
    // descending number wraps the gap
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(5), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(5), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(5), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(64'h2_0000_0000), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_FLUSH, DOC_W'(64'h5_5555_5555), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_W'(64'h4_0000_0000), 5,
                             gap_b(8'h40, 1'b0), gap_b(8'h00, 1'b0),
                             gap_b(8'h00, 1'b0), gap_b(8'h00, 1'b0),
                             gap_b(8'h80, 1'b1)));
    dir_tab.push_back(mk_row(REQ_POSTING, '0, FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, DOC_MAX, FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_POSTING, '0, FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_FLUSH, DOC_W'(64'h2_AAAA_AAAA), FROM_PREDICTOR));
    dir_tab.push_back(mk_row(REQ_FLUSH, DOC_MAX, 0));

    // reset
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      typed_n   = dir_tab[i].n_typed;
      typed_res = dir_tab[i].typed;
      send_req(dir_tab[i].kind, dir_tab[i].doc);
    end
    typed_n = FROM_PREDICTOR;
    pause_sender();

    // random terms: ascending documents with repeats, some wrap-arounds and
    // stray flushes
    items       = 0;
    mid_drained = 1'b0;
    while (items < RANDOM_ITEMS) begin
      if (!mid_drained && items >= RANDOM_ITEMS / 2) begin
        pause_sender();
        mid_drained = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_req(REQ_FLUSH, rand_doc());
        items = items + 1;
      end
      n_docs = $urandom_range(1, 8);
      doc    = '0;
      for (int d = 0; d < n_docs; d++) begin
        if ($urandom_range(0, 9) == 0) doc = rand_doc();
        else doc = doc + rand_gap();
        reps = $urandom_range(1, 3);
        repeat (reps) send_req(REQ_POSTING, doc);
        items = items + reps;
      end
      send_req(REQ_FLUSH, rand_doc());
      items = items + 1;
    end

    // drain and let the pipeline settle
    pause_sender();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d requests (%0d flushes), %0d output bytes checked,",
             req_count, flush_count, byte_count);
    $display("with random request gaps, output stalls and a full drain mid-run");
    if (err_count == 0) begin
      $display("posting_delta_vbyte_encoder_core: match");
    end else begin
      $display("posting_delta_vbyte_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- posting_delta_vbyte_encoder_core.f -----
hdl/pvbe_pkg.sv
hdl/pvbe_front.sv
hdl/pvbe_queue.sv
hdl/pvbe_back.sv
hdl/posting_delta_vbyte_encoder_core.sv
sim/tb_posting_delta_vbyte_encoder_core.sv
